// ----- src/pbvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbvs_pkg: shared types and constants for the page budget victim selector
// Slot count, page count widths, operation and status codes, and the
// command word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package pbvs_pkg;

  // Number of client slots and derived index widths.
  localparam int CLIENT_COUNT = 8;
  localparam int IDX_W        = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
  localparam int SCAN_W       = IDX_W + 1;

  // Field widths fixed by the interface.
  localparam int OP_W    = 3;
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 32;
  localparam int PAGE_W  = 31;

  localparam logic [PAGE_W-1:0] PAGE_MAX   = {PAGE_W{1'b1}};
  localparam logic [PAGE_W-1:0] POOL_RESET = PAGE_W'(65536);

  // Depth of the command queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADMIT   = 3'd0,
    OP_EVICT   = 3'd1,
    OP_DIRTY   = 3'd2,
    OP_SIG_ON  = 3'd3,
    OP_SIG_OFF = 3'd4
  } op_code_t;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_VICTIM  = 2'd1;
  localparam logic [1:0] STATUS_NO_CAND = 2'd2;
  localparam logic [1:0] STATUS_SAT     = 2'd3;

  // Command classes resolved by the front end.
  typedef enum logic [2:0] {
    CMD_ADMIT    = 3'd0,
    CMD_EVICT    = 3'd1,
    CMD_DIRTY    = 3'd2,
    CMD_SIG_ON   = 3'd3,
    CMD_SIG_OFF  = 3'd4,
    CMD_NOP      = 3'd5,
    CMD_REJECT   = 3'd6,
    CMD_BAD_SLOT = 3'd7
  } cmd_kind_t;

  typedef logic [IDX_W-1:0] slot_idx_t;

  typedef struct packed {
    cmd_kind_t           kind;
    slot_idx_t           slot;
    logic [COUNT_W-1:0]  count;
    logic [PAGE_W-1:0]   release_pages;
    logic [PAGE_W-1:0]   dirty_pages;
    logic                dirty_mode;
  } cmd_t;

  // One client's bookkeeping, stored as one memory row.
  typedef struct packed {
    logic              sig;
    logic [PAGE_W-1:0] peak;
    logic [PAGE_W-1:0] dirty;
    logic [PAGE_W-1:0] res;
  } client_row_t;

endpackage

// ----- src/page_budget_victim_selector_core.sv -----
`timescale 1ns / 1ps
// Flow: an accepted word is written into the queue, popped into the back end's
//   command register in idle, and its result word is registered from execute, or
//   from report after the victim scan for an admit that scans. The back end takes
//   the next queued word only once it is back in idle; the queue takes words meanwhile.
// Reset (synchronous, active high): free pool 65536, all client counts and
//   signalling flags read as zero at once through per-slot valid bits.
// ----------------------------------------------------------------------------
// page_budget_victim_selector_core: shared page pool with victim selection
// Front end decodes words into a short queue; back end applies them to the
// pool and the per-client memory and names a victim when an admit fails.
// ----------------------------------------------------------------------------
module page_budget_victim_selector_core
  import pbvs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration: a write loads the free pool directly.
  input  logic                cfg_we,
  input  logic [PAGE_W-1:0]   cfg_wdata,
  // Input word.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     operation,
  input  logic [SLOT_W-1:0]   requester,
  input  logic [COUNT_W-1:0]  page_count,
  input  logic [PAGE_W-1:0]   dirty_pages,
  input  logic                admit_dirty_mode,
  // Result word.
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [SLOT_W-1:0]   victim,
  output logic [PAGE_W-1:0]   free_pages,
  output logic [PAGE_W-1:0]   requester_resident,
  output logic [PAGE_W-1:0]   requester_peak
);

  // The queue decouples input acceptance from execution, so words keep
  // arriving while the back end scans or waits on a stalled result word.
  logic push;
  logic pop;
  logic q_full;
  logic q_not_empty;
  cmd_t front_cmd;
  cmd_t q_head;

  pbvs_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .requester        (requester),
    .page_count       (page_count),
    .dirty_pages      (dirty_pages),
    .admit_dirty_mode (admit_dirty_mode),
    .q_full           (q_full),
    .push             (push),
    .cmd              (front_cmd)
  );

  pbvs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .pop       (pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (q_head)
  );

  // The back end owns the execution state: the free pool register, the per-client
  // memory, and the output register that holds a result word until taken.
  pbvs_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .q_not_empty        (q_not_empty),
    .q_head             (q_head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .victim             (victim),
    .free_pages         (free_pages),
    .requester_resident (requester_resident),
    .requester_peak     (requester_peak)
  );

endmodule

// ----- src/pbvs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbvs_front: input word decode
// Checks the requester slot, classifies the operation and prepares the
// evict release amount, then hands the command word to the queue.
// ----------------------------------------------------------------------------
module pbvs_front
  import pbvs_pkg::*;
(
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     operation,
  input  logic [SLOT_W-1:0]   requester,
  input  logic [COUNT_W-1:0]  page_count,
  input  logic [PAGE_W-1:0]   dirty_pages,
  input  logic                admit_dirty_mode,
  input  logic                q_full,
  output logic                push,
  output cmd_t                cmd
);

  logic in_range;

  assign in_range = 32'(requester) < 32'(CLIENT_COUNT);
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    cmd.slot          = IDX_W'(requester);
    cmd.count         = page_count;
    cmd.dirty_pages   = dirty_pages;
    cmd.dirty_mode    = admit_dirty_mode;
    // A negative count releases nothing on evict.
    cmd.release_pages = page_count[COUNT_W-1] ? '0 : page_count[PAGE_W-1:0];
    cmd.kind          = CMD_NOP;
    if (!in_range) begin
      cmd.kind = CMD_BAD_SLOT;
    end else begin
      unique case (operation)
        OP_ADMIT: begin
          if (page_count[COUNT_W-1]) begin
            cmd.kind = CMD_REJECT;
          end else if (page_count == '0) begin
            cmd.kind = CMD_NOP;
          end else begin
            cmd.kind = CMD_ADMIT;
          end
        end
        OP_EVICT:   cmd.kind = CMD_EVICT;
        OP_DIRTY:   cmd.kind = CMD_DIRTY;
        OP_SIG_ON:  cmd.kind = CMD_SIG_ON;
        OP_SIG_OFF: cmd.kind = CMD_SIG_OFF;
        default:    cmd.kind = CMD_NOP;
      endcase
    end
  end

endmodule

// ----- src/pbvs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbvs_queue: command queue
// Short FIFO of decoded command words between the front and back ends.
// ----------------------------------------------------------------------------
module pbvs_queue
  import pbvs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic not_empty,
  output logic full,
  output cmd_t head
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign not_empty = fill != '0;
  assign full      = fill == QCNT_W'(QUEUE_DEPTH);
  assign head      = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- src/pbvs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbvs_back: command execution and victim scan
// Holds the free pool and the per-client memory, applies each command,
// scans the clients one per cycle when an admit does not fit, and keeps the
// result word in an output register.
// ----------------------------------------------------------------------------
module pbvs_back
  import pbvs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [PAGE_W-1:0]   cfg_wdata,
  input  logic                q_not_empty,
  input  cmd_t                q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [SLOT_W-1:0]   victim,
  output logic [PAGE_W-1:0]   free_pages,
  output logic [PAGE_W-1:0]   requester_resident,
  output logic [PAGE_W-1:0]   requester_peak
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_REPORT = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  cmd_t              cmd_q;
  logic [PAGE_W-1:0] free_pool;

  client_row_t       mem [CLIENT_COUNT];
  logic              row_valid [CLIENT_COUNT];
  client_row_t       rd_row;
  logic              rd_hit;
  slot_idx_t         rd_addr;
  client_row_t       row;

  logic [SCAN_W-1:0] scan_cnt;
  slot_idx_t         scan_idx;
  logic [PAGE_W-1:0] deficit;
  logic [PAGE_W-1:0] best_res;
  logic [PAGE_W-1:0] best_dirty;
  logic              pick_found;
  slot_idx_t         pick_idx;
  logic [PAGE_W-1:0] req_res;
  logic [PAGE_W-1:0] req_peak;

  logic              out_free;
  logic              wr_en;
  client_row_t       row_next;
  logic [PAGE_W-1:0] free_next;
  logic [1:0]        exec_status;
  logic [PAGE_W-1:0] exec_res;
  logic [PAGE_W-1:0] exec_peak;
  logic              admit_fits;
  logic [PAGE_W-1:0] admit_cnt;
  logic [PAGE_W:0]   res_sum;
  logic [PAGE_W:0]   free_sum;
  logic signed [PAGE_W+1:0] dirty_sum;
  logic              eligible;
  logic              better;

  assign out_free  = !out_valid || out_ready;
  assign row       = rd_hit ? rd_row : '0;
  assign admit_cnt = cmd_q.count[PAGE_W-1:0];
  assign admit_fits = admit_cnt <= free_pool;
  assign pop       = (state == ST_IDLE) && q_not_empty;
  assign scan_idx  = IDX_W'(scan_cnt - SCAN_W'(1));

  always_comb begin
    unique case (state)
      ST_IDLE: rd_addr = q_head.slot;
      ST_SCAN: rd_addr = IDX_W'(scan_cnt);
      default: rd_addr = cmd_q.slot;
    endcase
  end

  // Per-command update, evaluated against the requester's row.
  always_comb begin
    row_next    = row;
    wr_en       = 1'b0;
    free_next   = free_pool;
    exec_status = STATUS_DONE;
    exec_res    = row.res;
    exec_peak   = row.peak;
    res_sum     = {1'b0, row.res} + {1'b0, admit_cnt};
    free_sum    = {1'b0, free_pool} + {1'b0, cmd_q.release_pages};
    dirty_sum   = $signed({2'b00, row.dirty}) + $signed({cmd_q.count[COUNT_W-1], cmd_q.count});
    case (cmd_q.kind)
      CMD_ADMIT: begin
        if (admit_fits) begin
          wr_en     = 1'b1;
          free_next = free_pool - admit_cnt;
          if (res_sum[PAGE_W]) begin
            row_next.res = PAGE_MAX;
            exec_status  = STATUS_SAT;
          end else begin
            row_next.res = res_sum[PAGE_W-1:0];
          end
          if (row_next.res > row.peak) begin
            row_next.peak = row_next.res;
          end
        end
      end
      CMD_EVICT: begin
        wr_en = 1'b1;
        if (free_sum[PAGE_W]) begin
          free_next   = PAGE_MAX;
          exec_status = STATUS_SAT;
        end else begin
          free_next = free_sum[PAGE_W-1:0];
        end
        if (cmd_q.release_pages > row.res) begin
          row_next.res = '0;
          exec_status  = STATUS_SAT;
        end else begin
          row_next.res = row.res - cmd_q.release_pages;
        end
        if (cmd_q.dirty_pages > row.dirty) begin
          row_next.dirty = '0;
          exec_status    = STATUS_SAT;
        end else begin
          row_next.dirty = row.dirty - cmd_q.dirty_pages;
        end
      end
      CMD_DIRTY: begin
        wr_en = 1'b1;
        if (dirty_sum[PAGE_W+1]) begin
          row_next.dirty = '0;
          exec_status    = STATUS_SAT;
        end else if (dirty_sum[PAGE_W]) begin
          row_next.dirty = PAGE_MAX;
          exec_status    = STATUS_SAT;
        end else begin
          row_next.dirty = dirty_sum[PAGE_W-1:0];
        end
      end
      CMD_SIG_ON: begin
        wr_en        = 1'b1;
        row_next.sig = 1'b1;
      end
      CMD_SIG_OFF: begin
        wr_en        = 1'b1;
        row_next.sig = 1'b0;
      end
      CMD_REJECT: exec_status = STATUS_SAT;
      CMD_BAD_SLOT: begin
        exec_status = STATUS_NO_CAND;
        exec_res    = '0;
        exec_peak   = '0;
      end
      default: exec_status = STATUS_DONE;
    endcase
    if (cmd_q.kind != CMD_BAD_SLOT) begin
      exec_res  = row_next.res;
      exec_peak = row_next.peak;
    end
  end

  // Victim rule applied to the slot whose row is on the read port.
  always_comb begin
    eligible = (scan_idx != cmd_q.slot) && ((row.res != '0) || row.sig);
    better   = ((best_res < deficit) && (row.res > best_res)) ||
               ((row.res >= deficit) &&
                ((!cmd_q.dirty_mode && (row.res < best_res)) ||
                 (cmd_q.dirty_mode && (!pick_found || (row.dirty < best_dirty)))));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_not_empty) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_q.kind == CMD_ADMIT && !admit_fits) begin
          state_next = ST_SCAN;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == SCAN_W'(CLIENT_COUNT)) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Client memory with one read and one write port.
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && out_free && wr_en) begin
      mem[cmd_q.slot] <= row_next;
    end
    rd_row <= mem[rd_addr];
    rd_hit <= row_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLIENT_COUNT; i++) begin
        row_valid[i] <= 1'b0;
      end
    end else if (state == ST_EXEC && out_free && wr_en) begin
      row_valid[cmd_q.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      free_pool <= POOL_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        free_pool <= cfg_wdata;
      end else if (state == ST_EXEC && out_free && !(cmd_q.kind == CMD_ADMIT && !admit_fits)) begin
        free_pool <= free_next;
      end
      // A new result word replaces one taken at this edge; otherwise a taken
      // word clears the valid flag.
      if ((state == ST_EXEC && out_free && !(cmd_q.kind == CMD_ADMIT && !admit_fits)) ||
          (state == ST_REPORT && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_q <= q_head;
    end
    if (state == ST_EXEC) begin
      scan_cnt   <= '0;
      deficit    <= admit_cnt - free_pool;
      best_res   <= '0;
      best_dirty <= '0;
      pick_found <= 1'b0;
      pick_idx   <= '0;
      req_res    <= row.res;
      req_peak   <= row.peak;
      if (out_free) begin
        status             <= exec_status;
        victim             <= '0;
        free_pages         <= free_next;
        requester_resident <= exec_res;
        requester_peak     <= exec_peak;
      end
    end
    if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
      if (scan_cnt != '0 && eligible && better) begin
        pick_found <= 1'b1;
        pick_idx   <= scan_idx;
        best_res   <= row.res;
        best_dirty <= row.dirty;
      end
    end
    if (state == ST_REPORT && out_free) begin
      status             <= pick_found ? STATUS_VICTIM : STATUS_NO_CAND;
      victim             <= pick_found ? SLOT_W'(pick_idx) : '0;
      free_pages         <= free_pool;
      requester_resident <= req_res;
      requester_peak     <= req_peak;
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_cnt <= SCAN_W'(CLIENT_COUNT)))
    else $error("victim scan ran past the last client slot");

  a_victim_not_self: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && pick_found) |-> (pick_idx != cmd_q.slot))
    else $error("requester named as its own victim");

  a_pool_still_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !cfg_we) |=> $stable(free_pool))
    else $error("free pool changed during a victim scan");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EXEC || state == ST_REPORT))
    else $error("result word raised outside execute or report");

endmodule
